>>> rtl/core/acdb_pkg.sv
// Shared constants, codes and request descriptor type of the AHCI descriptor builder.
`default_nettype none
package acdb_pkg;

    localparam int ACDB_MAX_ENTRIES = 8;
    localparam int ACDB_SLOT_COUNT  = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 136;
    localparam int ENTRIES_W   = 13;
    localparam int SECT_SHIFT  = 4;
    localparam int STRIDE_SHIFT = 13;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SLOT   = 2'd1;
    localparam logic [1:0] ST_BAD_COUNT = 2'd2;

    localparam logic [7:0] OP_READ_DMA_EXT  = 8'h25;
    localparam logic [7:0] OP_WRITE_DMA_EXT = 8'h35;

    typedef struct packed {
        logic [1:0]           status;
        logic [4:0]           slot;
        logic                 is_write;
        logic [47:0]          block;
        logic [15:0]          count;
        logic [ENTRIES_W-1:0] entries;
        logic [31:0]          buf_addr;
    } t_desc;

endpackage
`default_nettype wire

>>> rtl/core/acdb_front.sv
// Request intake: free-slot search, entry count and request classification.
`default_nettype none
module acdb_front import acdb_pkg::*; #(
    parameter int MAX_ENTRIES = ACDB_MAX_ENTRIES,
    parameter int SLOT_COUNT  = ACDB_SLOT_COUNT
) (
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [IN_TDATA_W-1:0] i_data,
    output logic                       o_push,
    input  wire logic                  i_full,
    output t_desc                      o_desc
);

    logic        cmd;
    logic [47:0] blk;
    logic [15:0] cnt;
    logic [31:0] buf_addr;
    logic [31:0] busy;
    logic [4:0]  slot;
    logic        found;
    logic [ENTRIES_W-1:0] entries;
    logic        bad_count;

    assign cmd      = i_data[0];
    assign blk      = i_data[48:1];
    assign cnt      = i_data[64:49];
    assign buf_addr = i_data[96:65];
    assign busy     = i_data[128:97];

    always_comb begin
        slot  = 5'd0;
        found = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!busy[i]) begin
                slot  = 5'(i);
                found = 1'b1;
            end
        end
    end

    assign entries   = {1'b0, cnt[15:SECT_SHIFT]} + ENTRIES_W'(|cnt[SECT_SHIFT-1:0]);
    assign bad_count = (cnt == 16'd0) || (entries > ENTRIES_W'(MAX_ENTRIES));

    assign o_ready = !i_full && i_rst_n;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_desc.slot     = found ? slot : 5'd0;
        o_desc.is_write = cmd;
        o_desc.block    = blk;
        o_desc.count    = cnt;
        o_desc.entries  = entries;
        o_desc.buf_addr = buf_addr;
        if (!found) begin
            o_desc.status = ST_NO_SLOT;
        end else if (bad_count) begin
            o_desc.status = ST_BAD_COUNT;
        end else begin
            o_desc.status = ST_OK;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/acdb_queue.sv
// Short descriptor queue between intake and entry generation.
`default_nettype none
module acdb_queue import acdb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_desc      o_desc
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_desc            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/acdb_back.sv
// Entry generation: one scatter entry result per cycle into the output register, unless stalled.
`default_nettype none
module acdb_back import acdb_pkg::*; #(
    parameter int MAX_ENTRIES = ACDB_MAX_ENTRIES
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire t_desc                  i_desc,
    output logic                        o_pop,
    output logic                        o_tvalid,
    input  wire logic                   i_tready,
    output logic [OUT_TDATA_W-1:0]      o_tdata,
    output logic                        o_tlast
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       n_idx;
    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_tdata;
    logic [OUT_TDATA_W-1:0] n_tdata;
    logic                   r_last;
    logic                   n_last;
    logic                   load;
    logic                   ok;
    logic [ENTRIES_W-1:0]   idx_ext;
    logic [3:0]             total;
    logic [2:0]             index;
    logic [31:0]            addr;
    logic [12:0]            bytes;

    assign ok      = (i_desc.status == ST_OK);
    assign idx_ext = ENTRIES_W'(r_idx);
    assign n_last  = !ok || (idx_ext == i_desc.entries - 1'b1);
    assign load    = i_valid && (!r_valid || i_tready);
    assign o_pop   = load && n_last;
    assign n_idx   = o_pop ? '0 : (load ? r_idx + 1'b1 : r_idx);

    always_comb begin
        if (ok) begin
            total = i_desc.entries[3:0];
            index = idx_ext[2:0];
            addr  = i_desc.buf_addr + (32'(idx_ext) << STRIDE_SHIFT);
            bytes = n_last ? {i_desc.count[3:0] - 4'd1, 9'h1FF} : 13'h1FFF;
        end else begin
            total = 4'd0;
            index = 3'd0;
            addr  = 32'd0;
            bytes = 13'd0;
        end
        n_tdata = {4'd0, bytes, addr, index, total, i_desc.count, i_desc.block,
                   (i_desc.is_write ? OP_WRITE_DMA_EXT : OP_READ_DMA_EXT),
                   i_desc.is_write, i_desc.slot, i_desc.status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tdata <= n_tdata;
            r_last  <= n_last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_last;

endmodule
`default_nettype wire

>>> rtl/core/ahci_command_descriptor_builder.sv
// Top level of the AHCI command slot and scatter-table descriptor builder.
//
// Slave stream: one disk request per accepted beat (s_axis_tvalid && s_axis_tready).
// The intake picks the lowest free command slot, counts scatter entries of 16 sectors
// and checks the count, then queues the request in a two-entry descriptor queue.
// Master stream: one result per scatter entry, one per cycle while m_axis_tready is
// high, with m_axis_tlast on the final result of the request; a rejected request
// gives a single result. Requests pass through the queue, then the output register.
// Entries: a request of N entries (1 to MAX_ENTRIES) gives N results, counted out
// by the entry counter of the generator; intake can queue new requests while the
// generator is still busy with an earlier one.
// Reset: the queue and output register are emptied and s_axis_tready is low while
// i_rst_n is low.
// Stall: while m_axis_tready is low the output register holds its result, the
// generator waits, and intake continues until the queue is full.
`default_nettype none
module ahci_command_descriptor_builder import acdb_pkg::*; #(
    parameter int MAX_ENTRIES = ACDB_MAX_ENTRIES,
    parameter int SLOT_COUNT  = ACDB_SLOT_COUNT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // command, start_block, sector_count, buffer_address, busy_slots, zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status, slot, is_write, ata_opcode, frame_block, frame_count, entry_total,
    // entry_index, entry_address, entry_bytes_minus_one, zero pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast
);

    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    t_desc front_desc;
    t_desc q_desc;

    acdb_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SLOT_COUNT  (SLOT_COUNT)
    ) u_front (
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_push  (push),
        .i_full  (full),
        .o_desc  (front_desc)
    );

    acdb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    acdb_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_desc   (q_desc),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire
